// ----- design/gamc_pkg.sv -----
// Shared types, codes and limits for the gas alarm mode controller.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package gamc_pkg;

   // Field and limit widths
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned TEMP_W   = 6;
   localparam int unsigned AQ_W     = 11;
   localparam int unsigned CO_W     = 9;

   // Operation codes of an incoming beat
   localparam logic [2:0] OP_KEY        = 3'd0;
   localparam logic [2:0] OP_SAMPLE     = 3'd1;
   localparam logic [2:0] OP_SET_MODE   = 3'd2;
   localparam logic [2:0] OP_SET_CTRL   = 3'd3;
   localparam logic [2:0] OP_SET_LIMITS = 3'd4;
   localparam logic [2:0] OP_STATUS     = 3'd5;

   // Front panel keys that act
   localparam logic [2:0] KEY_MODE   = 3'd1;
   localparam logic [2:0] KEY_SELECT = 3'd2;
   localparam logic [2:0] KEY_UP     = 3'd3;
   localparam logic [2:0] KEY_DOWN   = 3'd4;

   // Fan and alarm command codes (anything else leaves the output alone)
   localparam logic [1:0] CMD_OFF = 2'd1;
   localparam logic [1:0] CMD_ON  = 2'd2;

   // Manual device selection
   localparam logic DEV_FAN   = 1'b0;
   localparam logic DEV_ALARM = 1'b1;

   // Threshold selection
   localparam logic [1:0] SEL_TEMP = 2'd0;
   localparam logic [1:0] SEL_AQ   = 2'd1;
   localparam logic [1:0] SEL_CO   = 2'd2;

   typedef enum logic [1:0] {
      MODE_AUTO      = 2'd0,
      MODE_MANUAL    = 2'd1,
      MODE_THRESHOLD = 2'd2
   } mode_type;

   typedef logic [TEMP_W-1:0] temp_limit_type;
   typedef logic [AQ_W-1:0]   aq_limit_type;
   typedef logic [CO_W-1:0]   co_limit_type;

   // Threshold limits and steps
   localparam temp_limit_type TEMP_DEFAULT = 6'd35;
   localparam temp_limit_type TEMP_MIN     = 6'd10;
   localparam temp_limit_type TEMP_MAX     = 6'd60;
   localparam temp_limit_type TEMP_STEP    = 6'd1;
   localparam aq_limit_type   AQ_DEFAULT   = 11'd500;
   localparam aq_limit_type   AQ_MIN       = 11'd100;
   localparam aq_limit_type   AQ_MAX       = 11'd2000;
   localparam aq_limit_type   AQ_STEP      = 11'd50;
   localparam co_limit_type   CO_DEFAULT   = 9'd100;
   localparam co_limit_type   CO_MIN       = 9'd10;
   localparam co_limit_type   CO_MAX       = 9'd500;
   localparam co_limit_type   CO_STEP      = 9'd10;

   // One request beat
   typedef struct packed {
      logic [2:0]           op;
      logic [2:0]           key_id;
      logic [1:0]           new_mode;
      logic signed [15:0]   temp_value;
      logic signed [16:0]   aq_value;
      logic signed [16:0]   co_value;
      logic                 temp_present;
      logic                 aq_present;
      logic                 co_present;
      logic [1:0]           fan_cmd;
      logic [1:0]           alarm_cmd;
   } req_type;

   // One response beat
   typedef struct packed {
      logic           fan_out;
      logic           alarm_out;
      mode_type       mode_out;
      logic           device_sel_out;
      logic [1:0]     threshold_sel_out;
      temp_limit_type temp_limit_out;
      aq_limit_type   aq_limit_out;
      co_limit_type   co_limit_out;
      logic           telemetry_request;
   } rsp_type;

   // Controller state
   typedef struct packed {
      mode_type                    mode;
      logic                        device_sel;
      logic [1:0]                  threshold_sel;
      logic                        fan;
      logic                        alarm;
      temp_limit_type              temp_limit;
      aq_limit_type                aq_limit;
      co_limit_type                co_limit;
      logic signed [SAMPLE_W-1:0]  last_temp;
      logic [SAMPLE_W-1:0]         last_aq;
      logic [SAMPLE_W-1:0]         last_co;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode:          MODE_AUTO,
      device_sel:    DEV_FAN,
      threshold_sel: SEL_TEMP,
      fan:           1'b0,
      alarm:         1'b0,
      temp_limit:    TEMP_DEFAULT,
      aq_limit:      AQ_DEFAULT,
      co_limit:      CO_DEFAULT,
      last_temp:     '0,
      last_aq:       '0,
      last_co:       '0
   };

endpackage

// ----- design/gamc_in_reg.sv -----
// Input register of the gas alarm mode controller: holds one request beat.
// Depends on gamc_pkg.
`timescale 1ns / 1ps

module gamc_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gamc_pkg::req_type req_in,
   input  logic             slot_free,
   output logic             fire,
   output gamc_pkg::req_type stage
);
   import gamc_pkg::*;

   logic    hold_valid_ff;
   logic    hold_valid_in;
   req_type stage_ff;

   // Beat moves on when the result register can take it
   assign fire      = hold_valid_ff & slot_free;
   assign req_ready = ~hold_valid_ff | fire;
   assign stage     = stage_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_valid && req_ready) begin
         hold_valid_in = 1'b1;
      end else if (fire) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   // Payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_ff <= req_in;
      end
   end

endmodule

// ----- design/gamc_step.sv -----
// Controller state and its combinational update rule for one request beat.
// Depends on gamc_pkg.
`timescale 1ns / 1ps

module gamc_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  gamc_pkg::req_type stage,
   output gamc_pkg::rsp_type rsp_in
);
   import gamc_pkg::*;

   state_type state_ff;
   state_type state_in;

   logic signed [SAMPLE_W-1:0] temp_smp;
   logic [SAMPLE_W-1:0]        aq_smp;
   logic [SAMPLE_W-1:0]        co_smp;
   logic                       over;
   logic                       go_auto;
   logic                       assess_en;
   logic                       tele;

   logic [TEMP_W:0]  temp_sum;
   logic [AQ_W:0]    aq_sum;
   logic [CO_W:0]    co_sum;
   temp_limit_type   temp_up;
   aq_limit_type     aq_up;
   co_limit_type     co_up;
   temp_limit_type   temp_dn;
   aq_limit_type     aq_dn;
   co_limit_type     co_dn;
   temp_limit_type   temp_clamp;
   aq_limit_type     aq_clamp;
   co_limit_type     co_clamp;

   // Samples as they stand after this beat (negative AQ/CO read as zero)
   always_comb begin
      temp_smp = state_ff.last_temp;
      aq_smp   = state_ff.last_aq;
      co_smp   = state_ff.last_co;
      if (stage.op == OP_SAMPLE) begin
         temp_smp = stage.temp_value;
         aq_smp   = stage.aq_value[16] ? '0 : stage.aq_value[SAMPLE_W-1:0];
         co_smp   = stage.co_value[16] ? '0 : stage.co_value[SAMPLE_W-1:0];
      end
   end

   // Any reading over its threshold
   assign over = ($signed(temp_smp) > $signed({{(SAMPLE_W-TEMP_W){1'b0}}, state_ff.temp_limit}))
              || (aq_smp > {{(SAMPLE_W-AQ_W){1'b0}}, state_ff.aq_limit})
              || (co_smp > {{(SAMPLE_W-CO_W){1'b0}}, state_ff.co_limit});

   // Saturating step up
   assign temp_sum = {1'b0, state_ff.temp_limit} + {1'b0, TEMP_STEP};
   assign aq_sum   = {1'b0, state_ff.aq_limit} + {1'b0, AQ_STEP};
   assign co_sum   = {1'b0, state_ff.co_limit} + {1'b0, CO_STEP};
   assign temp_up  = (temp_sum > {1'b0, TEMP_MAX}) ? TEMP_MAX : temp_sum[TEMP_W-1:0];
   assign aq_up    = (aq_sum > {1'b0, AQ_MAX}) ? AQ_MAX : aq_sum[AQ_W-1:0];
   assign co_up    = (co_sum > {1'b0, CO_MAX}) ? CO_MAX : co_sum[CO_W-1:0];

   // Step down only while above the minimum
   assign temp_dn = (state_ff.temp_limit > TEMP_MIN) ? state_ff.temp_limit - TEMP_STEP
                                                     : state_ff.temp_limit;
   assign aq_dn   = (state_ff.aq_limit > AQ_MIN) ? state_ff.aq_limit - AQ_STEP
                                                 : state_ff.aq_limit;
   assign co_dn   = (state_ff.co_limit > CO_MIN) ? state_ff.co_limit - CO_STEP
                                                 : state_ff.co_limit;

   // Remote thresholds clamped to their limits
   always_comb begin
      if (stage.temp_value < $signed({{(SAMPLE_W-TEMP_W){1'b0}}, TEMP_MIN})) begin
         temp_clamp = TEMP_MIN;
      end else if (stage.temp_value > $signed({{(SAMPLE_W-TEMP_W){1'b0}}, TEMP_MAX})) begin
         temp_clamp = TEMP_MAX;
      end else begin
         temp_clamp = stage.temp_value[TEMP_W-1:0];
      end
      if (stage.aq_value < $signed({{(17-AQ_W){1'b0}}, AQ_MIN})) begin
         aq_clamp = AQ_MIN;
      end else if (stage.aq_value > $signed({{(17-AQ_W){1'b0}}, AQ_MAX})) begin
         aq_clamp = AQ_MAX;
      end else begin
         aq_clamp = stage.aq_value[AQ_W-1:0];
      end
      if (stage.co_value < $signed({{(17-CO_W){1'b0}}, CO_MIN})) begin
         co_clamp = CO_MIN;
      end else if (stage.co_value > $signed({{(17-CO_W){1'b0}}, CO_MAX})) begin
         co_clamp = CO_MAX;
      end else begin
         co_clamp = stage.co_value[CO_W-1:0];
      end
   end

   // Next state for the beat in the input register
   always_comb begin
      state_in  = state_ff;
      go_auto   = 1'b0;
      assess_en = 1'b0;
      tele      = 1'b0;
      state_in.last_temp = temp_smp;
      state_in.last_aq   = aq_smp;
      state_in.last_co   = co_smp;
      case (stage.op)
         OP_KEY: begin
            case (stage.key_id)
               KEY_MODE: begin
                  case (state_ff.mode)
                     MODE_AUTO:   state_in.mode = MODE_MANUAL;
                     MODE_MANUAL: state_in.mode = MODE_THRESHOLD;
                     default:     go_auto = 1'b1;
                  endcase
               end
               KEY_SELECT: begin
                  if (state_ff.mode == MODE_MANUAL) begin
                     state_in.device_sel = ~state_ff.device_sel;
                  end else if (state_ff.mode == MODE_THRESHOLD) begin
                     case (state_ff.threshold_sel)
                        SEL_TEMP: state_in.threshold_sel = SEL_AQ;
                        SEL_AQ:   state_in.threshold_sel = SEL_CO;
                        default:  state_in.threshold_sel = SEL_TEMP;
                     endcase
                  end
               end
               KEY_UP: begin
                  if (state_ff.mode == MODE_MANUAL) begin
                     case (state_ff.device_sel)
                        DEV_FAN: state_in.fan   = ~state_ff.fan;
                        default: state_in.alarm = ~state_ff.alarm;
                     endcase
                  end else if (state_ff.mode == MODE_THRESHOLD) begin
                     tele = 1'b1;
                     case (state_ff.threshold_sel)
                        SEL_TEMP: state_in.temp_limit = temp_up;
                        SEL_AQ:   state_in.aq_limit   = aq_up;
                        default:  state_in.co_limit   = co_up;
                     endcase
                  end
               end
               KEY_DOWN: begin
                  if (state_ff.mode == MODE_THRESHOLD) begin
                     tele = 1'b1;
                     case (state_ff.threshold_sel)
                        SEL_TEMP: state_in.temp_limit = temp_dn;
                        SEL_AQ:   state_in.aq_limit   = aq_dn;
                        default:  state_in.co_limit   = co_dn;
                     endcase
                  end
               end
               default: ;
            endcase
         end
         OP_SAMPLE: begin
            assess_en = (state_ff.mode == MODE_AUTO);
         end
         OP_SET_MODE: begin
            tele = 1'b1;
            case (stage.new_mode)
               MODE_AUTO:      go_auto = 1'b1;
               MODE_MANUAL:    state_in.mode = MODE_MANUAL;
               MODE_THRESHOLD: state_in.mode = MODE_THRESHOLD;
               default: ;
            endcase
         end
         OP_SET_CTRL: begin
            tele = 1'b1;
            case (stage.fan_cmd)
               CMD_OFF: state_in.fan = 1'b0;
               CMD_ON:  state_in.fan = 1'b1;
               default: ;
            endcase
            case (stage.alarm_cmd)
               CMD_OFF: state_in.alarm = 1'b0;
               CMD_ON:  state_in.alarm = 1'b1;
               default: ;
            endcase
         end
         OP_SET_LIMITS: begin
            tele = 1'b1;
            if (stage.temp_present) begin
               state_in.temp_limit = temp_clamp;
            end
            if (stage.aq_present) begin
               state_in.aq_limit = aq_clamp;
            end
            if (stage.co_present) begin
               state_in.co_limit = co_clamp;
            end
         end
         OP_STATUS: tele = 1'b1;
         default: ;
      endcase
      // Entering auto: outputs cleared then reassessed, which nets to the assessment
      if (go_auto) begin
         state_in.mode = MODE_AUTO;
      end
      if (go_auto || assess_en) begin
         state_in.fan   = over;
         state_in.alarm = over;
      end
   end

   // Result fields after this beat
   always_comb begin
      rsp_in.fan_out           = state_in.fan;
      rsp_in.alarm_out         = state_in.alarm;
      rsp_in.mode_out          = state_in.mode;
      rsp_in.device_sel_out    = state_in.device_sel;
      rsp_in.threshold_sel_out = state_in.threshold_sel;
      rsp_in.temp_limit_out    = state_in.temp_limit;
      rsp_in.aq_limit_out      = state_in.aq_limit;
      rsp_in.co_limit_out      = state_in.co_limit;
      rsp_in.telemetry_request = tele;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_sel_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff.threshold_sel == SEL_TEMP || state_ff.threshold_sel == SEL_AQ ||
      state_ff.threshold_sel == SEL_CO)
      else $error("threshold selection out of range");

   a_limits_max: assert property (@(posedge clock) disable iff (reset)
      state_ff.temp_limit <= TEMP_MAX && state_ff.aq_limit <= AQ_MAX &&
      state_ff.co_limit <= CO_MAX)
      else $error("threshold above its maximum");

   a_auto_tied: assert property (@(posedge clock) disable iff (reset)
      fire && stage.op == OP_SAMPLE && state_ff.mode == MODE_AUTO
      |=> state_ff.fan == state_ff.alarm)
      else $error("fan and alarm differ after auto assessment");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(state_ff))
      else $error("state changed without a beat");
`endif

endmodule

// ----- design/gamc_rsp_reg.sv -----
// Result register of the gas alarm mode controller: holds one response beat.
// Depends on gamc_pkg.
`timescale 1ns / 1ps

module gamc_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  gamc_pkg::rsp_type rsp_in,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic              slot_free,
   output gamc_pkg::rsp_type rsp_data
);
   import gamc_pkg::*;

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;

   // Free when empty or the waiting beat leaves this cycle
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- design/gas_alarm_mode_controller_core.sv -----
// Top level of the gas alarm mode controller core.
// Depends on gamc_pkg, gamc_in_reg, gamc_step and gamc_rsp_reg.
`timescale 1ns / 1ps

// Air-quality alarm controller with auto, manual and threshold modes. Every
// request beat (key press, sensor sample, mode, control, threshold or status
// command) gives exactly one response beat carrying the fan and alarm drive,
// the mode, both selections, the three thresholds and a telemetry flag. One
// beat is taken per clock cycle while the response side does not stall. An
// accepted request waits in the input register while the state update runs,
// and the result register takes the outcome once it is free, from where the
// response is presented. req_ready depends combinationally on rsp_ready, so
// stalls on the response side reach the request side in the same cycle and no
// beat is dropped.
module gas_alarm_mode_controller_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_op,
   input  logic [2:0]         req_key_id,
   input  logic [1:0]         req_new_mode,
   input  logic signed [15:0] req_temp_value,
   input  logic signed [16:0] req_aq_value,
   input  logic signed [16:0] req_co_value,
   input  logic               req_temp_present,
   input  logic               req_aq_present,
   input  logic               req_co_present,
   input  logic [1:0]         req_fan_cmd,
   input  logic [1:0]         req_alarm_cmd,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_fan_out,
   output logic               rsp_alarm_out,
   output logic [1:0]         rsp_mode_out,
   output logic               rsp_device_sel_out,
   output logic [1:0]         rsp_threshold_sel_out,
   output logic [5:0]         rsp_temp_limit_out,
   output logic [10:0]        rsp_aq_limit_out,
   output logic [8:0]         rsp_co_limit_out,
   output logic               rsp_telemetry_request
);
   import gamc_pkg::*;

   req_type req_in;
   req_type stage;
   rsp_type rsp_in;
   rsp_type rsp_data;
   logic    fire;
   logic    slot_free;

   // Gather request fields
   always_comb begin
      req_in.op           = req_op;
      req_in.key_id       = req_key_id;
      req_in.new_mode     = req_new_mode;
      req_in.temp_value   = req_temp_value;
      req_in.aq_value     = req_aq_value;
      req_in.co_value     = req_co_value;
      req_in.temp_present = req_temp_present;
      req_in.aq_present   = req_aq_present;
      req_in.co_present   = req_co_present;
      req_in.fan_cmd      = req_fan_cmd;
      req_in.alarm_cmd    = req_alarm_cmd;
   end

   gamc_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_in    (req_in),
      .slot_free (slot_free),
      .fire      (fire),
      .stage     (stage)
   );

   gamc_step u_step (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .stage  (stage),
      .rsp_in (rsp_in)
   );

   gamc_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .rsp_in    (rsp_in),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .slot_free (slot_free),
      .rsp_data  (rsp_data)
   );

   // Spread response fields
   assign rsp_fan_out           = rsp_data.fan_out;
   assign rsp_alarm_out         = rsp_data.alarm_out;
   assign rsp_mode_out          = rsp_data.mode_out;
   assign rsp_device_sel_out    = rsp_data.device_sel_out;
   assign rsp_threshold_sel_out = rsp_data.threshold_sel_out;
   assign rsp_temp_limit_out    = rsp_data.temp_limit_out;
   assign rsp_aq_limit_out      = rsp_data.aq_limit_out;
   assign rsp_co_limit_out      = rsp_data.co_limit_out;
   assign rsp_telemetry_request = rsp_data.telemetry_request;

endmodule
